// ===== sv/wrs_pkg.sv =====
// ----------------------------------------------------------------------------
// Weighted roulette selector package
// Shared widths, command codes, state encoding and reset constants.
// ----------------------------------------------------------------------------
package wrs_pkg;

    localparam int FUNC_W   = 3;
    localparam int IDX_W    = 10;
    localparam int WEIGHT_W = 8;
    localparam int RND_W    = 32;
    localparam int WC_W     = 11;
    // Largest total: 2047 entries of weight 255.
    localparam int SUM_W    = WEIGHT_W + WC_W;
    localparam int RBIT_W   = $clog2(RND_W);

    localparam int                DEF_MAX_ENTRIES = 1024;
    localparam logic [WC_W-1:0]   WC_RESET        = 11'd1024;
    localparam logic [WEIGHT_W-1:0] WEIGHT_RESET  = 8'hFF;
    localparam logic [WEIGHT_W-1:0] WEIGHT_SAT    = 8'hFF;

    typedef enum logic [FUNC_W-1:0] {
        FN_SELECT  = 3'd0,
        FN_KNOWN   = 3'd1,
        FN_UNKNOWN = 3'd2,
        FN_WRITE   = 3'd3,
        FN_READ    = 3'd4
    } t_func;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SUM,
        ST_DIV,
        ST_SCAN,
        ST_RMW,
        ST_RESULT
    } t_state;

endpackage

// ===== sv/wrs_if.sv =====
// ----------------------------------------------------------------------------
// Weighted roulette selector channels
// Request, response and configuration channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface wrs_req_if;
    logic                          valid;
    logic                          ready;
    logic [wrs_pkg::FUNC_W-1:0]    func;
    logic [wrs_pkg::IDX_W-1:0]     entry_index;
    logic [wrs_pkg::WEIGHT_W-1:0]  weight_in;
    logic [wrs_pkg::RND_W-1:0]     random_value;

    modport source (output valid, func, entry_index, weight_in, random_value, input ready);
    modport sink   (input valid, func, entry_index, weight_in, random_value, output ready);
endinterface

interface wrs_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [wrs_pkg::IDX_W-1:0]     chosen_index;
    logic                          none_left;
    logic [wrs_pkg::WEIGHT_W-1:0]  weight_out;

    modport source (output valid, chosen_index, none_left, weight_out, input ready);
    modport sink   (input valid, chosen_index, none_left, weight_out, output ready);
endinterface

interface wrs_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [wrs_pkg::WC_W-1:0]      word_count;

    modport source (output valid, word_count, input ready);
    modport sink   (input valid, word_count, output ready);
endinterface

// ===== sv/wrs_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-port-write, single-port-read RAM
// One write and one read per cycle, read data registered.
// ----------------------------------------------------------------------------
module wrs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/weighted_roulette_selector_unit.sv =====
// ----------------------------------------------------------------------------
// Weighted roulette selector
// Table of weights in RAM; select picks an entry with probability in
// proportion to its weight, other commands update or read one weight.
// ----------------------------------------------------------------------------
//  Channel   Direction  Payload
//  i_req     in         func, entry_index, weight_in, random_value
//  o_rsp     out        chosen_index, none_left, weight_out
//  i_cfg     in         word_count
//
//  Select makes one RAM pass that sums the weights, runs a radix-2 remainder
//  unit over the random word, and makes a second RAM pass that scans the
//  bands. Other commands read one weight, modify it and write it back (read
//  writes nothing back). After reset a clearing pass loads every weight
//  with 255 before the first request is taken. A finished response
//  waits in the output register; a stalled sink holds the block in its result
//  state but a new request is already taken while the old response waits.
// ----------------------------------------------------------------------------
module weighted_roulette_selector_unit #(
    parameter int MAX_ENTRIES = wrs_pkg::DEF_MAX_ENTRIES
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    wrs_req_if.sink   i_req,
    wrs_rsp_if.source o_rsp,
    wrs_cfg_if.sink   i_cfg
);

    localparam int AW    = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W = AW + 1;
    localparam int IW    = wrs_pkg::IDX_W;
    localparam int WW    = wrs_pkg::WEIGHT_W;
    localparam int SW    = wrs_pkg::SUM_W;
    localparam int RW    = wrs_pkg::RND_W;
    localparam int BW    = wrs_pkg::RBIT_W;

    wrs_pkg::t_state    r_state, n_state;
    logic [CNT_W-1:0]   r_ra, n_ra;
    logic               r_dv, n_dv;
    logic [AW-1:0]      r_di, n_di;
    logic [SW-1:0]      r_sum, n_sum;
    logic [SW-1:0]      r_rem, n_rem;
    logic [BW-1:0]      r_bit, n_bit;
    logic [wrs_pkg::WC_W-1:0] r_word_count;

    logic [wrs_pkg::FUNC_W-1:0] r_func, n_func;
    logic [AW-1:0]      r_idx, n_idx;
    logic [WW-1:0]      r_win, n_win;
    logic [RW-1:0]      r_rnd, n_rnd;

    logic [IW-1:0]      r_res_chosen, n_res_chosen;
    logic               r_res_none, n_res_none;
    logic [WW-1:0]      r_res_w, n_res_w;

    logic               r_out_valid, n_out_valid;
    logic [IW-1:0]      r_out_chosen, n_out_chosen;
    logic               r_out_none, n_out_none;
    logic [WW-1:0]      r_out_w, n_out_w;

    logic               ram_we, ram_re;
    logic [AW-1:0]      ram_waddr, ram_raddr;
    logic [WW-1:0]      ram_wdata, ram_rdata;

    logic [CNT_W-1:0]   n_use;
    logic               idx_ok;
    logic [SW:0]        rem_sh;
    logic               req_fire;

    wrs_ram #(
        .WIDTH (WW),
        .DEPTH (MAX_ENTRIES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Entries in use: the configured count clamped to the table depth.
    always_comb begin
        if (32'(r_word_count) > MAX_ENTRIES) begin
            n_use = CNT_W'(MAX_ENTRIES);
        end else begin
            n_use = CNT_W'(r_word_count);
        end
    end

    assign idx_ok   = 32'(i_req.entry_index) < 32'(n_use);
    assign req_fire = i_req.valid && i_req.ready;
    assign rem_sh   = {r_rem, r_rnd[RW-1]};

    assign i_req.ready = (r_state == wrs_pkg::ST_IDLE);
    assign i_cfg.ready = 1'b1;

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.chosen_index = r_out_chosen;
    assign o_rsp.none_left    = r_out_none;
    assign o_rsp.weight_out   = r_out_w;

    always_comb begin
        n_state      = r_state;
        n_ra         = r_ra;
        n_dv         = 1'b0;
        n_di         = r_di;
        n_sum        = r_sum;
        n_rem        = r_rem;
        n_bit        = r_bit;
        n_func       = r_func;
        n_idx        = r_idx;
        n_win        = r_win;
        n_rnd        = r_rnd;
        n_res_chosen = r_res_chosen;
        n_res_none   = r_res_none;
        n_res_w      = r_res_w;
        n_out_valid  = r_out_valid && !o_rsp.ready;
        n_out_chosen = r_out_chosen;
        n_out_none   = r_out_none;
        n_out_w      = r_out_w;
        ram_we       = 1'b0;
        ram_waddr    = r_ra[AW-1:0];
        ram_wdata    = wrs_pkg::WEIGHT_RESET;
        ram_re       = 1'b0;
        ram_raddr    = r_ra[AW-1:0];

        unique case (r_state)
            wrs_pkg::ST_CLEAR: begin
                ram_we = 1'b1;
                n_ra   = r_ra + 1'b1;
                if (r_ra == CNT_W'(MAX_ENTRIES - 1)) begin
                    n_state = wrs_pkg::ST_IDLE;
                end
            end

            wrs_pkg::ST_IDLE: begin
                n_res_chosen = '0;
                n_res_none   = 1'b0;
                n_res_w      = '0;
                if (req_fire) begin
                    n_func = i_req.func;
                    n_idx  = AW'(i_req.entry_index);
                    n_win  = i_req.weight_in;
                    n_rnd  = i_req.random_value;
                    n_ra   = '0;
                    n_sum  = '0;
                    n_rem  = '0;
                    n_bit  = '0;
                    unique case (i_req.func) inside
                        wrs_pkg::FN_SELECT: begin
                            n_state = wrs_pkg::ST_SUM;
                        end
                        wrs_pkg::FN_KNOWN, wrs_pkg::FN_UNKNOWN,
                        wrs_pkg::FN_WRITE, wrs_pkg::FN_READ: begin
                            if (idx_ok) begin
                                ram_re    = 1'b1;
                                ram_raddr = AW'(i_req.entry_index);
                                n_state   = wrs_pkg::ST_RMW;
                            end else begin
                                n_state = wrs_pkg::ST_RESULT;
                            end
                        end
                        default: begin
                            n_state = wrs_pkg::ST_RESULT;
                        end
                    endcase
                end
            end

            wrs_pkg::ST_SUM: begin
                // Reads run one ahead of the accumulator.
                if (r_ra < n_use) begin
                    ram_re = 1'b1;
                    n_ra   = r_ra + 1'b1;
                    n_dv   = 1'b1;
                end
                if (r_dv) begin
                    n_sum = r_sum + SW'(ram_rdata);
                end
                if (!(r_ra < n_use) && !r_dv) begin
                    if (r_sum == '0) begin
                        n_res_none = 1'b1;
                        n_state    = wrs_pkg::ST_RESULT;
                    end else begin
                        n_state = wrs_pkg::ST_DIV;
                    end
                end
            end

            wrs_pkg::ST_DIV: begin
                // Restoring remainder, one bit of the random word per cycle.
                if (rem_sh >= {1'b0, r_sum}) begin
                    n_rem = SW'(rem_sh - {1'b0, r_sum});
                end else begin
                    n_rem = SW'(rem_sh);
                end
                n_rnd = {r_rnd[RW-2:0], 1'b0};
                n_bit = r_bit + 1'b1;
                if (r_bit == BW'(RW - 1)) begin
                    n_ra    = '0;
                    n_state = wrs_pkg::ST_SCAN;
                end
            end

            wrs_pkg::ST_SCAN: begin
                if (r_ra < n_use) begin
                    ram_re = 1'b1;
                    n_ra   = r_ra + 1'b1;
                    n_dv   = 1'b1;
                end
                if (r_dv) begin
                    if (r_rem < SW'(ram_rdata)) begin
                        n_res_chosen = IW'(r_di);
                        n_res_w      = ram_rdata;
                        n_dv         = 1'b0;
                        n_state      = wrs_pkg::ST_RESULT;
                    end else begin
                        n_rem = r_rem - SW'(ram_rdata);
                    end
                end else if (!(r_ra < n_use)) begin
                    n_state = wrs_pkg::ST_RESULT;
                end
            end

            wrs_pkg::ST_RMW: begin
                ram_waddr = r_idx;
                ram_we    = 1'b1;
                case (r_func)
                    wrs_pkg::FN_KNOWN:   ram_wdata = {2'b00, ram_rdata[WW-1:2]};
                    wrs_pkg::FN_UNKNOWN: ram_wdata = ram_rdata[WW-1] ? wrs_pkg::WEIGHT_SAT
                                                                     : {ram_rdata[WW-2:0], 1'b0};
                    wrs_pkg::FN_WRITE:   ram_wdata = r_win;
                    default: begin
                        ram_wdata = ram_rdata;
                        ram_we    = 1'b0;
                    end
                endcase
                n_res_w = ram_wdata;
                n_state = wrs_pkg::ST_RESULT;
            end

            wrs_pkg::ST_RESULT: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid  = 1'b1;
                    n_out_chosen = r_res_chosen;
                    n_out_none   = r_res_none;
                    n_out_w      = r_res_w;
                    n_state      = wrs_pkg::ST_IDLE;
                end
            end

            default: begin
                n_state = wrs_pkg::ST_IDLE;
            end
        endcase

        n_di = r_ra[AW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= wrs_pkg::ST_CLEAR;
            r_ra         <= '0;
            r_dv         <= 1'b0;
            r_out_valid  <= 1'b0;
            r_word_count <= wrs_pkg::WC_RESET;
        end else begin
            r_state     <= n_state;
            r_ra        <= n_ra;
            r_dv        <= n_dv;
            r_out_valid <= n_out_valid;
            if (i_cfg.valid && i_cfg.ready) begin
                r_word_count <= i_cfg.word_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_di         <= n_di;
        r_sum        <= n_sum;
        r_rem        <= n_rem;
        r_bit        <= n_bit;
        r_func       <= n_func;
        r_idx        <= n_idx;
        r_win        <= n_win;
        r_rnd        <= n_rnd;
        r_res_chosen <= n_res_chosen;
        r_res_none   <= n_res_none;
        r_res_w      <= n_res_w;
        r_out_chosen <= n_out_chosen;
        r_out_none   <= n_out_none;
        r_out_w      <= n_out_w;
    end

`ifndef NO_ASSERTIONS
    // The table RAM is never read and written in the same cycle.
    a_ram_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(ram_re && ram_we))
        else $error("table read and write overlap");

    // The remainder unit only runs on a nonzero total.
    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == wrs_pkg::ST_DIV) |-> (r_sum != '0))
        else $error("remainder started with zero total");

    // During the scan the residue stays inside the total weight.
    a_scan_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == wrs_pkg::ST_SCAN) |-> (r_rem < r_sum))
        else $error("scan residue out of range");

    // A response appears only when leaving the result state.
    a_rsp_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == wrs_pkg::ST_RESULT))
        else $error("response without result state");

    // An empty table reports no entry and no weight.
    a_none_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_none) |-> (r_out_chosen == '0 && r_out_w == '0))
        else $error("none_left with nonzero fields");
`endif

endmodule

// ===== bench/tb_weighted_roulette_selector_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Weighted roulette selector testbench
// Sends select, quarter, double, write, read and undefined requests under
// several word counts, with random idling on both channels. A behavioral
// copy of the weight table predicts every response, which is then compared
// field by field in arrival order.
// ----------------------------------------------------------------------------
module tb_weighted_roulette_selector_unit;

    localparam int                  FUNC_W      = wrs_pkg::FUNC_W;
    localparam int                  IDX_W       = wrs_pkg::IDX_W;
    localparam int                  WEIGHT_W    = wrs_pkg::WEIGHT_W;
    localparam int                  RND_W       = wrs_pkg::RND_W;
    localparam int                  WC_W        = wrs_pkg::WC_W;
    localparam int                  NUM_ENTRIES = wrs_pkg::DEF_MAX_ENTRIES;
    localparam int                  IDLE_PCT    = 23;
    localparam int                  MAX_PRINTED = 50;
    localparam logic [FUNC_W-1:0]   FUNC_TOP    = {FUNC_W{1'b1}};
    localparam logic [RND_W-1:0]    RND_ONES    = {RND_W{1'b1}};
    localparam logic [IDX_W-1:0]    IDX_TOP     = {IDX_W{1'b1}};
    localparam logic [WEIGHT_W-1:0] WEIGHT_ZERO = '0;
    localparam logic [WEIGHT_W-1:0] WEIGHT_SAT  = wrs_pkg::WEIGHT_SAT;
    localparam logic [WC_W-1:0]     WC_TOP      = {WC_W{1'b1}};

    typedef struct {
        logic [FUNC_W-1:0]   func;
        logic [IDX_W-1:0]    entry_index;
        logic [WEIGHT_W-1:0] weight_in;
        logic [RND_W-1:0]    random_value;
    } t_wrs_cmd;

    typedef struct {
        logic [IDX_W-1:0]    chosen_index;
        logic                none_left;
        logic [WEIGHT_W-1:0] weight_out;
    } t_wrs_res;

    logic i_clk;
    logic i_rst_n;

    wrs_req_if req_if ();
    wrs_rsp_if rsp_if ();
    wrs_cfg_if cfg_if ();

    weighted_roulette_selector_unit #(.MAX_ENTRIES(NUM_ENTRIES)) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if),
        .i_cfg   (cfg_if)
    );

    logic [WEIGHT_W-1:0] weight_mirror [NUM_ENTRIES];
    logic [WC_W-1:0]     mirror_word_count;
    t_wrs_res            pending_results [$];
    t_wrs_res            oldest_result;
    bit                  steady;
    int                  mismatches;
    int                  requests_sent;
    int                  selects_sent;
    int                  results_checked;
    int                  empty_draws;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #10ms;
        $display("weighted_roulette_selector_unit verification failed");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= MAX_PRINTED) begin
            $display("[%0t] MISMATCH: %s", $time, msg);
        end
    endtask

    // Applies one request to the mirrored table and returns the response it causes.
    function automatic t_wrs_res roulette_predict(input t_wrs_cmd cmd);
        t_wrs_res          res;
        int unsigned       in_use;
        int unsigned       total;
        int unsigned       band;
        logic [WEIGHT_W:0] w;
        res.chosen_index = '0;
        res.none_left    = 1'b0;
        res.weight_out   = '0;
        in_use = (mirror_word_count > NUM_ENTRIES) ? NUM_ENTRIES : mirror_word_count;
        if (cmd.func == wrs_pkg::FN_SELECT) begin
            total = 0;
            for (int i = 0; i < in_use; i++) total += weight_mirror[i];
            if (total == 0) begin
                res.none_left = 1'b1;
            end else begin
                band = cmd.random_value % total;
                for (int i = 0; i < in_use; i++) begin
                    if (band < weight_mirror[i]) begin
                        res.chosen_index = IDX_W'(i);
                        res.weight_out   = weight_mirror[i];
                        break;
                    end
                    band -= weight_mirror[i];
                end
            end
        end else if (cmd.func <= wrs_pkg::FN_READ && cmd.entry_index < in_use) begin
            w = {1'b0, weight_mirror[cmd.entry_index]};
            case (cmd.func)
                wrs_pkg::FN_KNOWN: begin
                    w = w >> 2;
                end
                wrs_pkg::FN_UNKNOWN: begin
                    w = w << 1;
                    if (w > WEIGHT_SAT) w = WEIGHT_SAT;
                end
                wrs_pkg::FN_WRITE: begin
                    w = cmd.weight_in;
                end
                default: ;
            endcase
            weight_mirror[cmd.entry_index] = w[WEIGHT_W-1:0];
            res.weight_out = w[WEIGHT_W-1:0];
        end
        return res;
    endfunction

    // Returns right after the accepting edge, with valid still high.
    task automatic send_cmd(input logic [FUNC_W-1:0] func, input logic [IDX_W-1:0] idx,
                            input logic [WEIGHT_W-1:0] win, input logic [RND_W-1:0] rnd);
        t_wrs_cmd cmd;
        cmd.func         = func;
        cmd.entry_index  = idx;
        cmd.weight_in    = win;
        cmd.random_value = rnd;
        while (!steady && $urandom_range(99) < IDLE_PCT) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid        <= 1'b1;
        req_if.func         <= func;
        req_if.entry_index  <= idx;
        req_if.weight_in    <= win;
        req_if.random_value <= rnd;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        pending_results.push_back(roulette_predict(cmd));
        requests_sent++;
        if (func == wrs_pkg::FN_SELECT) selects_sent++;
    endtask

    task automatic drain_results();
        req_if.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // The block is idle once every response is back, since each request has one.
    task automatic write_word_count(input logic [WC_W-1:0] count);
        drain_results();
        cfg_if.valid      <= 1'b1;
        cfg_if.word_count <= count;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        cfg_if.valid <= 1'b0;
        mirror_word_count = count;
    endtask

    task automatic test_reset_weights();
        send_cmd(wrs_pkg::FN_READ, '0, WEIGHT_ZERO, '0);
        send_cmd(wrs_pkg::FN_READ, IDX_TOP, WEIGHT_ZERO, '0);
        send_cmd(wrs_pkg::FN_SELECT, '0, WEIGHT_ZERO, '0);
        send_cmd(wrs_pkg::FN_SELECT, IDX_TOP, WEIGHT_SAT, RND_ONES);
    endtask

    task automatic test_weight_commands();
        send_cmd(wrs_pkg::FN_KNOWN, IDX_W'(5), WEIGHT_ZERO, '0);
        send_cmd(wrs_pkg::FN_UNKNOWN, IDX_W'(5), WEIGHT_ZERO, '0);
        send_cmd(wrs_pkg::FN_UNKNOWN, IDX_W'(5), WEIGHT_ZERO, '0);
        // The third doubling runs into saturation.
        send_cmd(wrs_pkg::FN_UNKNOWN, IDX_W'(5), WEIGHT_ZERO, '0);
        send_cmd(wrs_pkg::FN_WRITE, IDX_TOP, WEIGHT_ZERO, RND_ONES);
        send_cmd(wrs_pkg::FN_READ, IDX_TOP, WEIGHT_SAT, '0);
        send_cmd(wrs_pkg::FN_KNOWN, IDX_TOP, WEIGHT_ZERO, '0);
        send_cmd(wrs_pkg::FN_WRITE, '0, WEIGHT_SAT, '0);
        send_cmd(wrs_pkg::FN_UNKNOWN, '0, WEIGHT_ZERO, '0);
        for (int f = wrs_pkg::FN_READ + 1; f <= FUNC_TOP; f++) begin
            send_cmd(FUNC_W'(f), IDX_W'(5), WEIGHT_SAT, RND_ONES);
        end
    endtask

    task automatic test_word_count_limits();
        write_word_count('0);
        send_cmd(wrs_pkg::FN_SELECT, '0, WEIGHT_ZERO, RND_ONES);
        send_cmd(wrs_pkg::FN_READ, '0, WEIGHT_ZERO, '0);
        send_cmd(wrs_pkg::FN_WRITE, '0, WEIGHT_W'(7), '0);
        write_word_count(WC_W'(2));
        send_cmd(wrs_pkg::FN_WRITE, '0, WEIGHT_ZERO, '0);
        send_cmd(wrs_pkg::FN_WRITE, IDX_W'(1), WEIGHT_ZERO, '0);
        send_cmd(wrs_pkg::FN_SELECT, '0, WEIGHT_ZERO, RND_ONES);
        send_cmd(wrs_pkg::FN_WRITE, IDX_W'(1), WEIGHT_W'(1), '0);
        send_cmd(wrs_pkg::FN_SELECT, '0, WEIGHT_ZERO, RND_ONES);
        send_cmd(wrs_pkg::FN_WRITE, IDX_W'(2), WEIGHT_W'(9), '0);
        // Counts above the table size are clamped to it.
        write_word_count(WC_TOP);
        send_cmd(wrs_pkg::FN_READ, IDX_TOP, WEIGHT_ZERO, '0);
        send_cmd(wrs_pkg::FN_SELECT, '0, WEIGHT_ZERO, $urandom);
    endtask

    // Loads the low entries with fresh weights, then mixes every request kind.
    task automatic test_random_mix(input logic [WC_W-1:0] count, input int items,
                                   input bit quiet);
        int unsigned          in_use;
        int unsigned          pick;
        logic [FUNC_W-1:0]    func;
        logic [IDX_W-1:0]     idx;
        logic [WEIGHT_W-1:0]  win;
        logic [RND_W-1:0]     rnd;
        write_word_count(count);
        steady = quiet;
        in_use = (count > NUM_ENTRIES) ? NUM_ENTRIES : count;
        for (int k = 0; k < items; k++) begin
            pick = $urandom_range(99);
            if (pick < 30)      func = wrs_pkg::FN_SELECT;
            else if (pick < 45) func = wrs_pkg::FN_KNOWN;
            else if (pick < 60) func = wrs_pkg::FN_UNKNOWN;
            else if (pick < 80) func = wrs_pkg::FN_WRITE;
            else if (pick < 92) func = wrs_pkg::FN_READ;
            else func = FUNC_W'($urandom_range(wrs_pkg::FN_READ + 1, FUNC_TOP));
            if (in_use != 0 && $urandom_range(99) < 85) idx = IDX_W'($urandom_range(in_use - 1));
            else                                         idx = IDX_W'($urandom);
            pick = $urandom_range(9);
            if (pick < 3)       win = WEIGHT_ZERO;
            else if (pick == 3) win = WEIGHT_SAT;
            else                win = WEIGHT_W'($urandom);
            pick = $urandom_range(9);
            if (pick == 0)      rnd = '0;
            else if (pick == 1) rnd = RND_ONES;
            else                rnd = $urandom;
            if (k < in_use && k < 16) begin
                func = wrs_pkg::FN_WRITE;
                idx  = IDX_W'(k);
            end
            send_cmd(func, idx, win, rnd);
        end
        steady = 1'b0;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("response with no request outstanding");
            end else begin
                oldest_result = pending_results.pop_front();
                results_checked++;
                if (rsp_if.none_left === 1'b1) empty_draws++;
                if (rsp_if.chosen_index !== oldest_result.chosen_index)
                    report_mismatch($sformatf("chosen_index %0d, expected %0d",
                        rsp_if.chosen_index, oldest_result.chosen_index));
                if (rsp_if.none_left !== oldest_result.none_left)
                    report_mismatch($sformatf("none_left %0b, expected %0b",
                        rsp_if.none_left, oldest_result.none_left));
                if (rsp_if.weight_out !== oldest_result.weight_out)
                    report_mismatch($sformatf("weight_out %0d, expected %0d",
                        rsp_if.weight_out, oldest_result.weight_out));
            end
        end
        rsp_if.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end

    initial begin
        i_rst_n             = 1'b0;
        req_if.valid        = 1'b0;
        req_if.func         = '0;
        req_if.entry_index  = '0;
        req_if.weight_in    = '0;
        req_if.random_value = '0;
        cfg_if.valid        = 1'b0;
        cfg_if.word_count   = '0;
        rsp_if.ready        = 1'b0;
        steady              = 1'b0;
        mismatches          = 0;
        requests_sent       = 0;
        selects_sent        = 0;
        results_checked     = 0;
        empty_draws         = 0;
        for (int i = 0; i < NUM_ENTRIES; i++) weight_mirror[i] = wrs_pkg::WEIGHT_RESET;
        mirror_word_count = wrs_pkg::WC_RESET;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_weights();
        test_weight_commands();
        test_word_count_limits();
        test_random_mix(WC_W'(3), 40, 1'b0);
        test_random_mix(WC_W'(16), 60, 1'b1);
        test_random_mix(WC_W'(1), 20, 1'b0);
        test_random_mix('0, 12, 1'b0);
        test_random_mix(WC_W'(64), 60, 1'b0);
        test_random_mix(WC_W'(200), 36, 1'b0);
        test_random_mix(WC_TOP, 24, 1'b0);

        drain_results();
        repeat (50) @(posedge i_clk);
        $display("Covered %0d requests, %0d of them selects (%0d with no weight left),",
                 requests_sent, selects_sent, empty_draws);
        $display("over word counts from 0 to the clamped maximum; %0d responses checked.",
                 results_checked);
        if (mismatches == 0) begin
            $display("weighted_roulette_selector_unit verification clean");
        end else begin
            $display("weighted_roulette_selector_unit verification failed");
        end
        $finish;
    end

endmodule

// ===== weighted_roulette_selector_unit.f =====
sv/wrs_pkg.sv
sv/wrs_if.sv
sv/wrs_ram.sv
sv/weighted_roulette_selector_unit.sv
bench/tb_weighted_roulette_selector_unit.sv
